/* rtl/core/lsws_pkg.sv */
// ----------------------------------------------------------------------------
// lsws_pkg
// Shared types and constants of the limit switch winch sequencer.
// ----------------------------------------------------------------------------
package lsws_pkg;

	// timer width and the width used for timer compares
	localparam int TIMER_W = 16;
	localparam int LIMIT_W = 16;
	localparam int CMP_W   = (TIMER_W > LIMIT_W) ? TIMER_W : LIMIT_W;

	// servo value after reset
	localparam logic [7:0] SERVO_RST = 8'd90;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_STOP_VALUE   = 3'd0,
		CFG_LOWER_VALUE  = 3'd1,
		CFG_RAISE_VALUE  = 3'd2,
		CFG_ACCEL_STEP   = 3'd3,
		CFG_BRAKE_STEP   = 3'd4,
		CFG_TIMEOUT      = 3'd5,
		CFG_SETTLE       = 3'd6,
		CFG_ACTIVE_LOW   = 3'd7
	} cfg_idx_t;

	// command codes of an input word
	typedef enum logic [2:0] {
		MODE_TICK  = 3'd0,
		MODE_LOWER = 3'd1,
		MODE_RAISE = 3'd2,
		MODE_STOP  = 3'd3,
		MODE_HOME  = 3'd4
	} mode_t;

	// sequencer phases
	typedef enum logic [3:0] {
		PH_STOPPED   = 4'd0,
		PH_LOWERING  = 4'd1,
		PH_BRAKE_LOW = 4'd2,
		PH_SETTLING  = 4'd3,
		PH_READY     = 4'd4,
		PH_RAISING   = 4'd5,
		PH_BRAKE_UP  = 4'd6,
		PH_FINISHED  = 4'd7,
		PH_TIMEOUT   = 4'd8
	} phase_t;

	// configuration register set
	typedef struct packed {
		logic [7:0]  stop_value;
		logic [7:0]  lower_value;
		logic [7:0]  raise_value;
		logic [7:0]  accel_step;
		logic [7:0]  brake_step;
		logic [15:0] timeout_ticks;
		logic [15:0] settle_ticks;
		logic        switch_active_low;
	} cfg_t;

	// input word
	typedef struct packed {
		logic [2:0] mode;
		logic       upper_switch;
		logic       lower_switch;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [7:0] servo_value;
		logic       servo_changed;
		logic [3:0] phase;
		logic       busy_res;
		logic       is_ready;
		logic       is_finished;
		logic       timed_out;
		logic       upper_reached;
		logic       lower_reached;
	} res_word_t;

endpackage

/* rtl/core/lsws_in_if.sv */
// ----------------------------------------------------------------------------
// lsws_in_if
// Valid/ready channel carrying one command or tick word.
// ----------------------------------------------------------------------------
interface lsws_in_if import lsws_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/lsws_out_if.sv */
// ----------------------------------------------------------------------------
// lsws_out_if
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface lsws_out_if import lsws_pkg::*; ();
	logic      valid;
	logic      ready;
	res_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/lsws_cfg_if.sv */
// ----------------------------------------------------------------------------
// lsws_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lsws_cfg_if import lsws_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/core/lsws_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lsws_cfg_regs
// Configuration register file, written one register per word.
// ----------------------------------------------------------------------------
module lsws_cfg_regs import lsws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  index,
	input  logic [15:0] wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_value        <= 8'd90;
			cfg_q.lower_value       <= 8'd60;
			cfg_q.raise_value       <= 8'd120;
			cfg_q.accel_step        <= 8'd2;
			cfg_q.brake_step        <= 8'd4;
			cfg_q.timeout_ticks     <= 16'd1000;
			cfg_q.settle_ticks      <= 16'd200;
			cfg_q.switch_active_low <= 1'b1;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(index))
				CFG_STOP_VALUE:  cfg_q.stop_value        <= wdata[7:0];
				CFG_LOWER_VALUE: cfg_q.lower_value       <= wdata[7:0];
				CFG_RAISE_VALUE: cfg_q.raise_value       <= wdata[7:0];
				CFG_ACCEL_STEP:  cfg_q.accel_step        <= wdata[7:0];
				CFG_BRAKE_STEP:  cfg_q.brake_step        <= wdata[7:0];
				CFG_TIMEOUT:     cfg_q.timeout_ticks     <= wdata;
				CFG_SETTLE:      cfg_q.settle_ticks      <= wdata;
				CFG_ACTIVE_LOW:  cfg_q.switch_active_low <= wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/lsws_seq.sv */
// ----------------------------------------------------------------------------
// lsws_seq
// Sequencer state and its next-state logic: phase machine, tick timer,
// switch flags and servo ramp. One word is applied per cycle when go is set.
// ----------------------------------------------------------------------------
module lsws_seq import lsws_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      go,
	input  in_word_t  item,
	output res_word_t res
);

	phase_t               phase_q, phase_d;
	logic [TIMER_W-1:0]   elapsed_q, elapsed_d, elapsed_inc;
	logic [7:0]           servo_now_q, servo_now_d;
	logic [7:0]           servo_goal_q, servo_goal_d;
	logic                 braking_q, braking_d;
	logic                 upper_q, upper_d;
	logic                 lower_q, lower_d;
	logic                 upper_smp, lower_smp;
	logic                 timeout_hit, settle_hit;
	logic [7:0]           step;
	logic [8:0]           sum_up, goal_plus;
	logic                 changed;

	// switch sampling with polarity
	assign upper_smp = item.upper_switch ^ cfg.switch_active_low;
	assign lower_smp = item.lower_switch ^ cfg.switch_active_low;

	// saturating timer and its limits
	assign elapsed_inc = (elapsed_q == {TIMER_W{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
	assign timeout_hit = CMP_W'(elapsed_inc) >= CMP_W'(cfg.timeout_ticks);
	assign settle_hit  = CMP_W'(elapsed_inc) >= CMP_W'(cfg.settle_ticks);

	// phase step and commands
	always_comb begin
		phase_d      = phase_q;
		elapsed_d    = elapsed_q;
		servo_goal_d = servo_goal_q;
		braking_d    = braking_q;
		upper_d      = upper_q;
		lower_d      = lower_q;
		unique case (mode_t'(item.mode))
			MODE_TICK: begin
				upper_d   = upper_smp;
				lower_d   = lower_smp;
				elapsed_d = elapsed_inc;
				unique case (phase_q)
					PH_LOWERING: begin
						if (timeout_hit) begin
							servo_goal_d = cfg.stop_value;
							braking_d    = 1'b1;
							phase_d      = PH_TIMEOUT;
						end else if (lower_smp) begin
							servo_goal_d = cfg.stop_value;
							braking_d    = 1'b1;
							phase_d      = PH_BRAKE_LOW;
						end
					end
					PH_BRAKE_LOW: begin
						if (servo_now_q == servo_goal_q) begin
							elapsed_d = '0;
							phase_d   = PH_SETTLING;
						end
					end
					PH_SETTLING: begin
						if (settle_hit) phase_d = PH_READY;
					end
					PH_RAISING: begin
						if (timeout_hit) begin
							servo_goal_d = cfg.stop_value;
							braking_d    = 1'b1;
							phase_d      = PH_TIMEOUT;
						end else if (upper_smp) begin
							servo_goal_d = cfg.stop_value;
							braking_d    = 1'b1;
							phase_d      = PH_BRAKE_UP;
						end
					end
					PH_BRAKE_UP: begin
						if (servo_now_q == servo_goal_q) phase_d = PH_FINISHED;
					end
					default: begin
					end
				endcase
			end
			MODE_LOWER: begin
				if (phase_q == PH_STOPPED) begin
					servo_goal_d = cfg.lower_value;
					braking_d    = 1'b0;
					elapsed_d    = '0;
					phase_d      = PH_LOWERING;
				end
			end
			MODE_RAISE: begin
				if (phase_q == PH_READY) begin
					servo_goal_d = cfg.raise_value;
					braking_d    = 1'b0;
					elapsed_d    = '0;
					phase_d      = PH_RAISING;
				end
			end
			MODE_STOP: begin
				servo_goal_d = cfg.stop_value;
				braking_d    = 1'b1;
				phase_d      = PH_STOPPED;
			end
			MODE_HOME: begin
				upper_d = upper_smp;
				lower_d = lower_smp;
				if (upper_smp) begin
					servo_goal_d = cfg.stop_value;
					braking_d    = 1'b1;
					phase_d      = PH_STOPPED;
				end else begin
					servo_goal_d = cfg.raise_value;
					braking_d    = 1'b0;
					elapsed_d    = '0;
					phase_d      = PH_RAISING;
				end
			end
			default: begin
			end
		endcase
	end

	// servo ramp toward the new goal, clamped at the goal, ticks only
	assign step      = braking_d ? cfg.brake_step : cfg.accel_step;
	assign sum_up    = {1'b0, servo_now_q} + {1'b0, step};
	assign goal_plus = {1'b0, servo_goal_d} + {1'b0, step};

	always_comb begin
		servo_now_d = servo_now_q;
		changed     = 1'b0;
		if (mode_t'(item.mode) == MODE_TICK && servo_now_q != servo_goal_d) begin
			changed = 1'b1;
			if (servo_now_q < servo_goal_d) begin
				servo_now_d = (sum_up > {1'b0, servo_goal_d}) ? servo_goal_d : sum_up[7:0];
			end else begin
				servo_now_d = ({1'b0, servo_now_q} < goal_plus) ? servo_goal_d
					: servo_now_q - step;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_STOPPED;
			elapsed_q    <= '0;
			servo_now_q  <= SERVO_RST;
			servo_goal_q <= SERVO_RST;
			braking_q    <= 1'b0;
			upper_q      <= 1'b0;
			lower_q      <= 1'b0;
		end else if (go) begin
			phase_q      <= phase_d;
			elapsed_q    <= elapsed_d;
			servo_now_q  <= servo_now_d;
			servo_goal_q <= servo_goal_d;
			braking_q    <= braking_d;
			upper_q      <= upper_d;
			lower_q      <= lower_d;
		end
	end

	// result word from the state after this word
	always_comb begin
		res.servo_value   = servo_now_d;
		res.servo_changed = changed;
		res.phase         = phase_d;
		res.busy_res      = (phase_d == PH_LOWERING) || (phase_d == PH_BRAKE_LOW) ||
			(phase_d == PH_SETTLING) || (phase_d == PH_RAISING) ||
			(phase_d == PH_BRAKE_UP);
		res.is_ready      = (phase_d == PH_READY);
		res.is_finished   = (phase_d == PH_FINISHED);
		res.timed_out     = (phase_d == PH_TIMEOUT);
		res.upper_reached = upper_d;
		res.lower_reached = lower_d;
	end

	// commands never move the servo
	a_cmd_no_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		go && item.mode != MODE_TICK |-> !changed && servo_now_d == servo_now_q)
		else $error("servo moved on a command word");

	// state holds between words
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(phase_q) && $stable(servo_now_q) && $stable(elapsed_q))
		else $error("sequencer state changed without a word");

	// ramp from below never passes the goal
	a_clamp_up: assert property (@(posedge clk) disable iff (!arst_n)
		go && servo_now_q < servo_goal_d |-> servo_now_d <= servo_goal_d)
		else $error("servo ramp passed its goal");

	// braking phases always ramp at the brake step
	a_brake_flag: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BRAKE_LOW || phase_q == PH_BRAKE_UP |-> braking_q)
		else $error("braking phase without brake flag");

endmodule

/* rtl/core/limit_switch_winch_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// limit_switch_winch_sequencer_unit
// Top level: input register, sequencer, result register, configuration.
// ----------------------------------------------------------------------------
// Each accepted word (a service tick or a lower, raise, stop or home command)
// gives exactly one result word. A word is captured in an input register,
// applied to the sequencer state by combinational logic and written to a
// result register, so one word per cycle is accepted for as long as results
// are taken; a stalled result register holds the pipeline and cmd.ready drops
// only when both stages are full and the result is not taken. The
// configuration port is always ready; write it only while no word is in
// flight.
module limit_switch_winch_sequencer_unit import lsws_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	lsws_in_if.sink     cmd,
	lsws_out_if.source  res,
	lsws_cfg_if.sink    cfg
);

	cfg_t      cfg_val;
	logic      valid_s1;
	in_word_t  item_s1;
	logic      valid_s2;
	res_word_t res_s2;
	res_word_t seq_res;
	logic      advance;
	logic      go;

	// configuration registers
	assign cfg.ready = 1'b1;

	lsws_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg.valid),
		.index  (cfg.index),
		.wdata  (cfg.wdata),
		.cfg    (cfg_val)
	);

	// handshake control
	assign advance   = !valid_s2 || res.ready;
	assign go        = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	// sequencer
	lsws_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_val),
		.go     (go),
		.item   (item_s1),
		.res    (seq_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_s2 <= seq_res;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = res_s2;

endmodule
